// ----- hdl/scr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, constants and width helpers for the stroke coverage
// rasterizer.
// ----------------------------------------------------------------------------
package scr_pkg;

   // default coordinate width of pixels and shape corners
   localparam int COORD_BITS_DEF = 14;

   // quotient bits of the projection divide (t is Q.32)
   localparam int DIV_BITS = 32;
   // split point of t for the two partial products
   localparam int T_SPLIT = 16;
   // t * |d| is scaled down by this to land in Q.12
   localparam int OX_SHIFT = 24;
   // squared distance Q.24 goes to Q.16 before the root
   localparam int D2_SHIFT = 8;

   // segment lanes: four rectangle edges, or shaft and two head strokes
   localparam int NUM_LANES = 4;

   // register stages inside one segment lane
   localparam int LANE_LAT = 4 + DIV_BITS + 5;

   // head points: signed Q16.4, packed y[39:20] x[19:0]
   localparam int HEAD_BITS = 20;
   localparam int HEAD_WORD = 2 * HEAD_BITS;

   localparam int LW_BITS  = 8;
   localparam int COV_BITS = 8;
   localparam logic [COV_BITS-1:0] COV_FULL = '1;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = HEAD_WORD;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SHAPE_MODE = 3'd0,
      CSR_FIRST_X    = 3'd1,
      CSR_FIRST_Y    = 3'd2,
      CSR_SECOND_X   = 3'd3,
      CSR_SECOND_Y   = 3'd4,
      CSR_HEAD_ONE   = 3'd5,
      CSR_HEAD_TWO   = 3'd6,
      CSR_LINE_WIDTH = 3'd7
   } csr_index_type;

   typedef enum logic {
      SHAPE_RECT  = 1'b0,
      SHAPE_ARROW = 1'b1
   } shape_type;

   // signed width of a Q.4 point and of a difference of two points
   function automatic int pt_width(input int cb);
      pt_width = ((cb + 4 > HEAD_BITS - 1) ? cb + 4 : HEAD_BITS - 1) + 2;
   endfunction

   // width of a squared distance in Q.24
   function automatic int sq_width(input int cb);
      sq_width = 2 * (pt_width(cb) + 9) + 1;
   endfunction

endpackage

// ----- hdl/scr_seg_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_seg_lane
// Pipelined squared distance from a point to one segment: dot and length,
// a one-bit-per-stage restoring divide for t, split multiply for the
// offset, residual and its squared length.
// ----------------------------------------------------------------------------
module scr_seg_lane #(
   parameter int COORD_BITS = scr_pkg::COORD_BITS_DEF
) (
   input  logic                                            clock,
   input  logic signed [scr_pkg::pt_width(COORD_BITS)-1:0] pnt_x,
   input  logic signed [scr_pkg::pt_width(COORD_BITS)-1:0] pnt_y,
   input  logic signed [scr_pkg::pt_width(COORD_BITS)-1:0] beg_x,
   input  logic signed [scr_pkg::pt_width(COORD_BITS)-1:0] beg_y,
   input  logic signed [scr_pkg::pt_width(COORD_BITS)-1:0] end_x,
   input  logic signed [scr_pkg::pt_width(COORD_BITS)-1:0] end_y,
   output logic        [scr_pkg::sq_width(COORD_BITS)-1:0] dist2
);
   import scr_pkg::*;

   localparam int DW  = pt_width(COORD_BITS);
   localparam int LW  = 2 * DW;
   localparam int EW  = DW + 9;
   localparam int SQW = sq_width(COORD_BITS);
   localparam int TW  = DIV_BITS + 1;
   localparam int THW = TW - T_SPLIT;
   localparam int PRW = TW + DW - 1;
   localparam int OXW = PRW - OX_SHIFT;

   // stage 1: segment direction and point offset
   logic signed [DW-1:0] dx1_ff, dy1_ff, rx1_ff, ry1_ff;

   always_ff @(posedge clock) begin
      dx1_ff <= end_x - beg_x;
      dy1_ff <= end_y - beg_y;
      rx1_ff <= pnt_x - beg_x;
      ry1_ff <= pnt_y - beg_y;
   end

   // stage 2: products
   logic signed [LW-1:0] pdx2_ff, pdy2_ff, qdx2_ff, qdy2_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff, rx2_ff, ry2_ff;

   always_ff @(posedge clock) begin
      pdx2_ff <= rx1_ff * dx1_ff;
      pdy2_ff <= ry1_ff * dy1_ff;
      qdx2_ff <= dx1_ff * dx1_ff;
      qdy2_ff <= dy1_ff * dy1_ff;
      dx2_ff  <= dx1_ff;
      dy2_ff  <= dy1_ff;
      rx2_ff  <= rx1_ff;
      ry2_ff  <= ry1_ff;
   end

   // stage 3: dot product and squared length
   logic signed [LW:0]   dot3_ff;
   logic        [LW-1:0] len3_ff;
   logic signed [DW-1:0] dx3_ff, dy3_ff, rx3_ff, ry3_ff;

   always_ff @(posedge clock) begin
      dot3_ff <= (LW+1)'(pdx2_ff) + (LW+1)'(pdy2_ff);
      len3_ff <= $unsigned(qdx2_ff) + $unsigned(qdy2_ff);
      dx3_ff  <= dx2_ff;
      dy3_ff  <= dy2_ff;
      rx3_ff  <= rx2_ff;
      ry3_ff  <= ry2_ff;
   end

   // divider stages; index 0 holds the clamp flags and the start remainder
   logic        [LW:0]         rem_ff [0:DIV_BITS];
   logic        [LW-1:0]       len_ff [0:DIV_BITS];
   logic        [DIV_BITS-1:0] quo_ff [0:DIV_BITS];
   logic                       tz_ff  [0:DIV_BITS];
   logic                       tf_ff  [0:DIV_BITS];
   logic signed [DW-1:0]       dxs_ff [0:DIV_BITS];
   logic signed [DW-1:0]       dys_ff [0:DIV_BITS];
   logic signed [DW-1:0]       rxs_ff [0:DIV_BITS];
   logic signed [DW-1:0]       rys_ff [0:DIV_BITS];

   logic tz_in, tf_in;

   // t is zero for a point segment or a point behind the start, one past the end
   always_comb begin
      tz_in = (len3_ff == '0) || dot3_ff[LW] || (dot3_ff == '0);
      tf_in = !tz_in && (dot3_ff >= $signed({1'b0, len3_ff}));
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= (tz_in || tf_in) ? '0 : $unsigned(dot3_ff);
      len_ff[0] <= len3_ff;
      quo_ff[0] <= '0;
      tz_ff[0]  <= tz_in;
      tf_ff[0]  <= tf_in;
      dxs_ff[0] <= dx3_ff;
      dys_ff[0] <= dy3_ff;
      rxs_ff[0] <= rx3_ff;
      rys_ff[0] <= ry3_ff;
   end

   for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
      logic [LW:0] shl;
      logic [LW:0] dif;

      assign shl = {rem_ff[k-1][LW-1:0], 1'b0};
      assign dif = shl - {1'b0, len_ff[k-1]};

      // one quotient bit per stage
      always_ff @(posedge clock) begin
         if (shl >= {1'b0, len_ff[k-1]}) begin
            rem_ff[k] <= dif;
            quo_ff[k] <= {quo_ff[k-1][DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff[k] <= shl;
            quo_ff[k] <= {quo_ff[k-1][DIV_BITS-2:0], 1'b0};
         end
         len_ff[k] <= len_ff[k-1];
         tz_ff[k]  <= tz_ff[k-1];
         tf_ff[k]  <= tf_ff[k-1];
         dxs_ff[k] <= dxs_ff[k-1];
         dys_ff[k] <= dys_ff[k-1];
         rxs_ff[k] <= rxs_ff[k-1];
         rys_ff[k] <= rys_ff[k-1];
      end
   end

   // t selection and magnitudes of the direction
   logic        [TW-1:0] t_val;
   logic signed [DW-1:0] ndx, ndy;
   logic        [DW-2:0] mag_x, mag_y;

   always_comb begin
      if (tz_ff[DIV_BITS]) begin
         t_val = '0;
      end else if (tf_ff[DIV_BITS]) begin
         t_val = {1'b1, {DIV_BITS{1'b0}}};
      end else begin
         t_val = {1'b0, quo_ff[DIV_BITS]};
      end
      ndx   = -dxs_ff[DIV_BITS];
      ndy   = -dys_ff[DIV_BITS];
      mag_x = dxs_ff[DIV_BITS][DW-1] ? ndx[DW-2:0] : dxs_ff[DIV_BITS][DW-2:0];
      mag_y = dys_ff[DIV_BITS][DW-1] ? ndy[DW-2:0] : dys_ff[DIV_BITS][DW-2:0];
   end

   // partial products of t * |d|
   logic [T_SPLIT+DW-2:0] plx_ff, ply_ff;
   logic [THW+DW-2:0]     phx_ff, phy_ff;
   logic signed [DW-1:0]  rxm_ff, rym_ff;
   logic                  sgx_m_ff, sgy_m_ff;

   always_ff @(posedge clock) begin
      plx_ff   <= t_val[T_SPLIT-1:0] * mag_x;
      ply_ff   <= t_val[T_SPLIT-1:0] * mag_y;
      phx_ff   <= t_val[TW-1:T_SPLIT] * mag_x;
      phy_ff   <= t_val[TW-1:T_SPLIT] * mag_y;
      rxm_ff   <= rxs_ff[DIV_BITS];
      rym_ff   <= rys_ff[DIV_BITS];
      sgx_m_ff <= dxs_ff[DIV_BITS][DW-1];
      sgy_m_ff <= dys_ff[DIV_BITS][DW-1];
   end

   // offset along the segment in Q.12
   logic [PRW-1:0]       sum_x, sum_y;
   logic [OXW-1:0]       ox_ff, oy_ff;
   logic signed [DW-1:0] rxo_ff, ryo_ff;
   logic                 sgx_o_ff, sgy_o_ff;

   assign sum_x = PRW'(plx_ff) + (PRW'(phx_ff) << T_SPLIT);
   assign sum_y = PRW'(ply_ff) + (PRW'(phy_ff) << T_SPLIT);

   always_ff @(posedge clock) begin
      ox_ff    <= sum_x[PRW-1:OX_SHIFT];
      oy_ff    <= sum_y[PRW-1:OX_SHIFT];
      rxo_ff   <= rxm_ff;
      ryo_ff   <= rym_ff;
      sgx_o_ff <= sgx_m_ff;
      sgy_o_ff <= sgy_m_ff;
   end

   // residual vector magnitudes
   logic signed [EW:0]   rx_sc, ry_sc, ox_sc, oy_sc, sx, sy, nsx, nsy;
   logic        [EW-1:0] ex_ff, ey_ff;

   always_comb begin
      rx_sc = (EW+1)'($signed({rxo_ff, 8'b0}));
      ry_sc = (EW+1)'($signed({ryo_ff, 8'b0}));
      ox_sc = $signed((EW+1)'(ox_ff));
      oy_sc = $signed((EW+1)'(oy_ff));
      sx    = sgx_o_ff ? rx_sc + ox_sc : rx_sc - ox_sc;
      sy    = sgy_o_ff ? ry_sc + oy_sc : ry_sc - oy_sc;
      nsx   = -sx;
      nsy   = -sy;
   end

   always_ff @(posedge clock) begin
      ex_ff <= sx[EW] ? nsx[EW-1:0] : sx[EW-1:0];
      ey_ff <= sy[EW] ? nsy[EW-1:0] : sy[EW-1:0];
   end

   // squares, then their sum in Q.24
   logic [2*EW-1:0] sqx_ff, sqy_ff;
   logic [SQW-1:0]  d2_ff;

   always_ff @(posedge clock) begin
      sqx_ff <= ex_ff * ex_ff;
      sqy_ff <= ey_ff * ey_ff;
      d2_ff  <= SQW'(sqx_ff) + SQW'(sqy_ff);
   end

   assign dist2 = d2_ff;

endmodule

// ----- hdl/scr_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_isqrt
// Pipelined integer square root (floor), one result bit per stage.
// ----------------------------------------------------------------------------
module scr_isqrt #(
   parameter int IW = 53,
   parameter int NR = (IW + 1) / 2
) (
   input  logic          clock,
   input  logic [IW-1:0] radicand,
   output logic [NR-1:0] root
);
   import scr_pkg::*;

   localparam int RW = 2 * NR;

   logic [RW-1:0] rad_ff [1:NR];
   logic [RW-1:0] res_ff [1:NR];

   for (genvar i = 0; i < NR; i++) begin : g_stage
      localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (2 * (NR - 1 - i));
      logic [RW-1:0] cur_rad;
      logic [RW-1:0] cur_res;
      logic [RW:0]   trial;

      if (i == 0) begin : g_first
         assign cur_rad = RW'(radicand);
         assign cur_res = '0;
      end else begin : g_next
         assign cur_rad = rad_ff[i];
         assign cur_res = res_ff[i];
      end

      assign trial = {1'b0, cur_res} + {1'b0, BIT};

      // subtract the trial when it fits
      always_ff @(posedge clock) begin
         if ({1'b0, cur_rad} >= trial) begin
            rad_ff[i+1] <= cur_rad - trial[RW-1:0];
            res_ff[i+1] <= (cur_res >> 1) + BIT;
         end else begin
            rad_ff[i+1] <= cur_rad;
            res_ff[i+1] <= cur_res >> 1;
         end
      end
   end

   assign root = res_ff[NR][NR-1:0];

endmodule

// ----- hdl/stroke_coverage_rasterizer.sv -----
`timescale 1ns / 1ps
// Throughput: one pixel per cycle; busy stays low, every lane stage advances each cycle.
// The latency is set by the 32-stage projection divider and the root pipeline.
// Reset (synchronous): clears in-flight valid bits and the registers (line width to 1).
// Results cannot be stalled: rsp_valid is a one-cycle strobe per transaction.
// ----------------------------------------------------------------------------
// stroke_coverage_rasterizer
// Antialiased stroke coverage of one pixel per transaction against a
// rectangle outline or an arrow, from the smallest segment distance.
// ----------------------------------------------------------------------------
module stroke_coverage_rasterizer #(
   parameter int COORD_BITS = scr_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel requests
   input  logic                              start,
   output logic                              busy,
   input  logic [COORD_BITS-1:0]             req_pixel_x,
   input  logic [COORD_BITS-1:0]             req_pixel_y,
   // results
   output logic                              rsp_valid,
   output logic [scr_pkg::COV_BITS-1:0]      rsp_coverage,
   output logic [COORD_BITS-1:0]             rsp_out_x,
   output logic [COORD_BITS-1:0]             rsp_out_y,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [scr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [scr_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import scr_pkg::*;

   localparam int PTW = pt_width(COORD_BITS);
   localparam int SQW = sq_width(COORD_BITS);
   localparam int IW  = SQW - D2_SHIFT;
   localparam int NR  = (IW + 1) / 2;
   localparam int LAT = LANE_LAT + 3 + NR;

   // configuration registers
   shape_type                 shape_ff;
   logic [COORD_BITS-1:0]     first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic [HEAD_WORD-1:0]      head_one_ff, head_two_ff;
   logic [LW_BITS-1:0]        line_width_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff      <= SHAPE_RECT;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         second_x_ff   <= '0;
         second_y_ff   <= '0;
         head_one_ff   <= '0;
         head_two_ff   <= '0;
         line_width_ff <= LW_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SHAPE_MODE: begin
               shape_ff <= shape_type'(csr_wdata[0]);
            end
            CSR_FIRST_X: begin
               first_x_ff <= csr_wdata[COORD_BITS-1:0];
            end
            CSR_FIRST_Y: begin
               first_y_ff <= csr_wdata[COORD_BITS-1:0];
            end
            CSR_SECOND_X: begin
               second_x_ff <= csr_wdata[COORD_BITS-1:0];
            end
            CSR_SECOND_Y: begin
               second_y_ff <= csr_wdata[COORD_BITS-1:0];
            end
            CSR_HEAD_ONE: begin
               head_one_ff <= csr_wdata[HEAD_WORD-1:0];
            end
            CSR_HEAD_TWO: begin
               head_two_ff <= csr_wdata[HEAD_WORD-1:0];
            end
            CSR_LINE_WIDTH: begin
               line_width_ff <= csr_wdata[LW_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // points in Q.4
   logic                  accept;
   logic signed [PTW-1:0] pnt_x, pnt_y, ax, ay, bx, by, h1x, h1y, h2x, h2y;
   logic signed [PTW-1:0] seg_ax [0:NUM_LANES-1];
   logic signed [PTW-1:0] seg_ay [0:NUM_LANES-1];
   logic signed [PTW-1:0] seg_bx [0:NUM_LANES-1];
   logic signed [PTW-1:0] seg_by [0:NUM_LANES-1];

   assign accept = start && !busy;

   always_comb begin
      pnt_x = $signed({{(PTW-COORD_BITS-4){1'b0}}, req_pixel_x, 4'b1000});
      pnt_y = $signed({{(PTW-COORD_BITS-4){1'b0}}, req_pixel_y, 4'b1000});
      ax    = $signed({{(PTW-COORD_BITS-4){1'b0}}, first_x_ff, 4'b0000});
      ay    = $signed({{(PTW-COORD_BITS-4){1'b0}}, first_y_ff, 4'b0000});
      bx    = $signed({{(PTW-COORD_BITS-4){1'b0}}, second_x_ff, 4'b0000});
      by    = $signed({{(PTW-COORD_BITS-4){1'b0}}, second_y_ff, 4'b0000});
      h1x   = PTW'($signed(head_one_ff[HEAD_BITS-1:0]));
      h1y   = PTW'($signed(head_one_ff[HEAD_WORD-1:HEAD_BITS]));
      h2x   = PTW'($signed(head_two_ff[HEAD_BITS-1:0]));
      h2y   = PTW'($signed(head_two_ff[HEAD_WORD-1:HEAD_BITS]));
   end

   // segment endpoints per lane; arrow mode repeats the shaft in the spare lane
   always_comb begin
      case (shape_ff)
         SHAPE_ARROW: begin
            seg_ax[0] = ax;  seg_ay[0] = ay;  seg_bx[0] = bx;  seg_by[0] = by;
            seg_ax[1] = bx;  seg_ay[1] = by;  seg_bx[1] = h1x; seg_by[1] = h1y;
            seg_ax[2] = bx;  seg_ay[2] = by;  seg_bx[2] = h2x; seg_by[2] = h2y;
            seg_ax[3] = ax;  seg_ay[3] = ay;  seg_bx[3] = bx;  seg_by[3] = by;
         end
         default: begin
            seg_ax[0] = ax;  seg_ay[0] = ay;  seg_bx[0] = bx;  seg_by[0] = ay;
            seg_ax[1] = bx;  seg_ay[1] = ay;  seg_bx[1] = bx;  seg_by[1] = by;
            seg_ax[2] = bx;  seg_ay[2] = by;  seg_bx[2] = ax;  seg_by[2] = by;
            seg_ax[3] = ax;  seg_ay[3] = by;  seg_bx[3] = ax;  seg_by[3] = ay;
         end
      endcase
   end

   // segment distance lanes
   logic [SQW-1:0] lane_d2 [0:NUM_LANES-1];

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      scr_seg_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock (clock),
         .pnt_x (pnt_x),
         .pnt_y (pnt_y),
         .beg_x (seg_ax[g]),
         .beg_y (seg_ay[g]),
         .end_x (seg_bx[g]),
         .end_y (seg_by[g]),
         .dist2 (lane_d2[g])
      );
   end

   // two-level minimum
   logic [SQW-1:0] min_a_ff, min_b_ff, min_ff;

   always_ff @(posedge clock) begin
      min_a_ff <= (lane_d2[0] < lane_d2[1]) ? lane_d2[0] : lane_d2[1];
      min_b_ff <= (lane_d2[2] < lane_d2[3]) ? lane_d2[2] : lane_d2[3];
      min_ff   <= (min_a_ff < min_b_ff) ? min_a_ff : min_b_ff;
   end

   // distance in Q.8
   logic [NR-1:0] root;

   scr_isqrt #(
      .IW (IW),
      .NR (NR)
   ) u_isqrt (
      .clock    (clock),
      .radicand (min_ff[SQW-1:D2_SHIFT]),
      .root     (root)
   );

   // coverage from half width plus one half minus distance
   logic        [15:0]       base;
   logic signed [NR+1:0]     cov_v;
   logic        [8:0]        cov_c;
   logic        [16:0]       scaled;
   logic        [COV_BITS-1:0] cov_ff;

   always_comb begin
      base  = {1'b0, line_width_ff, 7'b0} + 16'd128;
      cov_v = $signed((NR+2)'(base)) - $signed((NR+2)'(root));
      if (cov_v < 0) begin
         cov_c = 9'd0;
      end else if (cov_v > 256) begin
         cov_c = 9'd256;
      end else begin
         cov_c = cov_v[8:0];
      end
      scaled = {cov_c, 8'b0} - 17'(cov_c) + 17'd128;
   end

   always_ff @(posedge clock) begin
      cov_ff <= scaled[15:8];
   end

   // valid bits and pixel echo
   logic [LAT-1:0]        vld_ff;
   logic [COORD_BITS-1:0] echo_x_ff [0:LAT-1];
   logic [COORD_BITS-1:0] echo_y_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      echo_x_ff[0] <= req_pixel_x;
      echo_y_ff[0] <= req_pixel_y;
      for (int i = 1; i < LAT; i++) begin
         echo_x_ff[i] <= echo_x_ff[i-1];
         echo_y_ff[i] <= echo_y_ff[i-1];
      end
   end

   assign rsp_valid    = vld_ff[LAT-1];
   assign rsp_coverage = cov_ff;
   assign rsp_out_x    = echo_x_ff[LAT-1];
   assign rsp_out_y    = echo_y_ff[LAT-1];

`ifndef SYNTHESIS
   // every accepted transaction comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted pixel did not produce a result");

   // no result without a matching accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !$past(accept, LAT) |-> !rsp_valid)
      else $error("result without an accepted pixel");

   // zero distance with a nonzero width is full coverage
   a_full_cov: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-2] && (root == '0) && (line_width_ff != '0) |=>
         rsp_coverage == COV_FULL)
      else $error("pixel on the stroke is not fully covered");
`endif

endmodule
